>>> rtl/assert_macros.svh
// Assertion macros used by the dimmer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high
`define ACPD_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high
`define ACPD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/acpd_pkg.sv
// Types and constants of the AC phase dimmer
package acpd_pkg;

  localparam int ACTION_W = 3;
  localparam int PERIOD_W = 16;
  localparam int BYTE_W   = 8;
  localparam int PROD_W   = 24;   // period times an 8-bit quotient
  localparam int Q_W      = 8;    // level / scale never exceeds 255
  localparam int MCNT_W   = 3;    // counts the Q_W multiplier bits
  localparam int LEFT_W   = 10;   // up to four times 255 steps
  localparam int CMD_LEN  = 4;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  localparam logic [BYTE_W-1:0]   FULL_BYTE     = 8'd255;
  localparam logic [PERIOD_W-1:0] MIN_PERIOD_RST = 16'd20000;
  localparam logic [BYTE_W-1:0]   CUTOFF_RST     = 8'd250;
  localparam logic [BYTE_W-1:0]   SYNC_RST       = 8'd81;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CROSS     = 3'd0,
    ACT_MATCH_ONE = 3'd1,
    ACT_MATCH_TWO = 3'd2,
    ACT_BYTE      = 3'd3,
    ACT_TIMEOUT   = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    REG_MIN_PERIOD = 2'd0,
    REG_CUTOFF     = 2'd1,
    REG_SYNC       = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MATCH,
    ST_TARGET,
    ST_LOAD,
    ST_LDIV,
    ST_XSTEP,
    ST_XQ,
    ST_XMUL,
    ST_XDIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]          gate;
    logic [PERIOD_W-1:0] delay_one;
    logic [PERIOD_W-1:0] delay_two;
    logic [1:0]          armed;
    logic                button_pressed;
    logic                send_sync;
    logic                timeout_running;
  } result_t;

endpackage

>>> rtl/acpd_if.sv
// Event and result channel interfaces of the AC phase dimmer
interface acpd_in_if;
  import acpd_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [PERIOD_W-1:0] period_count;
  logic [BYTE_W-1:0]   rx_byte;
  logic                button_low;

  modport source (output valid, action, period_count, rx_byte, button_low, input ready);
  modport sink (input valid, action, period_count, rx_byte, button_low, output ready);
endinterface

interface acpd_out_if;
  import acpd_pkg::*;

  logic                valid;
  logic                ready;
  logic                triac_one;
  logic                triac_two;
  logic [PERIOD_W-1:0] delay_one;
  logic [PERIOD_W-1:0] delay_two;
  logic                match_one_armed;
  logic                match_two_armed;
  logic                button_pressed;
  logic                send_sync;
  logic                timeout_running;

  modport source (output valid, triac_one, triac_two, delay_one, delay_two, match_one_armed,
                  match_two_armed, button_pressed, send_sync, timeout_running, input ready);
  modport sink (input valid, triac_one, triac_two, delay_one, delay_two, match_one_armed,
                match_two_armed, button_pressed, send_sync, timeout_running, output ready);
endinterface

>>> rtl/acpd_div.sv
// Bit-serial restoring divider, one quotient bit per cycle
module acpd_div #(
  parameter int DIVIDEND_W = 24,
  parameter int DIVISOR_W  = 17
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W);

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dvs;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    trial_sub;
  logic                  fits;

  // shift the next dividend bit into the partial remainder
  assign trial     = {rem, quo[DIVIDEND_W-1]};
  assign trial_sub = trial - {1'b0, dvs};
  assign fits      = (trial >= {1'b0, dvs});
  assign quotient  = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIVIDEND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo <= {quo[DIVIDEND_W-2:0], fits};
    end
  end

endmodule

>>> rtl/ac_phase_dimmer_with_fade_unit.sv
// Channel   | Dir | Beat carries
// ----------+-----+-----------------------------------------------------------------
// din       | in  | action, period_count, rx_byte, button_low
// dout      | out | triac gates, firing delays, armed bits, button, sync, timeout run
// apb       | in  | min_period (0x0), cutoff_level (0x4), sync_byte (0x8)
//
// One event at a time. A match runs EXEC, MATCH, DONE; a plain byte, timeout or spare
// action runs EXEC, DONE; a last command byte adds TARGET and LOAD per channel and a
// divide per nonzero fade length; a zero cross runs XSTEP, XQ, XMUL, XDIV per channel.
// The next event can be taken in the cycle after the result loads. The shared serial
// divider does two divides and a shift-add per channel on a zero cross, one per faded channel.
// Reset is synchronous and gives the power-up levels at once; no clearing pass.
// A stalled result waits in the output register while the next event runs; that event
// then holds in its last state until the result register frees.
`include "assert_macros.svh"

module ac_phase_dimmer_with_fade_unit #(
  parameter int LEVEL_SCALE = 10000
) (
  input  logic                          clk,
  input  logic                          rst,
  acpd_in_if.sink                       din,
  acpd_out_if.source                    dout,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [acpd_pkg::PADDR_W-1:0]  paddr,
  input  logic [acpd_pkg::PDATA_W-1:0]  pwdata,
  output logic [acpd_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import acpd_pkg::*;

  localparam int LEVEL_MAX = 255 * LEVEL_SCALE;
  localparam int LEVEL_W   = $clog2(LEVEL_MAX + 1);
  localparam int SCALE_W   = $clog2(LEVEL_SCALE + 1);
  localparam int DVW       = (SCALE_W > LEFT_W) ? SCALE_W : LEFT_W;

  // configuration
  logic [PERIOD_W-1:0] min_period;
  logic [BYTE_W-1:0]   cutoff_level;
  logic [BYTE_W-1:0]   sync_byte;
  logic [PROD_W-1:0]   thr;
  logic                cfg_wr;
  reg_idx_t            cfg_idx;

  // sequencer
  state_t state;
  state_t state_next;
  logic   accept;
  logic   ch;

  // latched event
  action_t             act;
  logic [PERIOD_W-1:0] period_in;
  logic [BYTE_W-1:0]   rx_in;
  logic                btn_in;

  // channel state
  logic [LEVEL_W-1:0]        level [2];
  logic signed [LEVEL_W:0]   step [2];
  logic [LEFT_W-1:0]         left [2];
  logic [PERIOD_W-1:0]       delay [2];
  logic [PERIOD_W-1:0]       last_period;
  logic [BYTE_W-1:0]         cmd [CMD_LEN];
  logic [1:0]                pos;
  logic                      timer_on;
  logic [1:0]                gate;
  logic [1:0]                armed;
  logic                      button_flag;
  logic                      sync_now;

  // working registers
  logic [LEVEL_W-1:0]  target;
  logic                neg;
  logic [Q_W-1:0]      mq;
  logic [PROD_W-1:0]   acc;
  logic [MCNT_W-1:0]   mcnt;

  // output register
  logic    out_valid;
  result_t out_data;

  // shared divider
  logic                div_start;
  logic [PROD_W-1:0]   div_dividend;
  logic [DVW-1:0]      div_divisor;
  logic                div_done;
  logic [PROD_W-1:0]   div_quo;

  // combinational datapath
  logic [LEVEL_W-1:0]      lvl_cur;
  logic signed [LEVEL_W:0] step_cur;
  logic [LEFT_W-1:0]       left_cur;
  logic [BYTE_W-1:0]       fade_cur;
  logic [BYTE_W-1:0]       bright_cur;
  logic signed [LEVEL_W:0] lvl_sum;
  logic [LEVEL_W-1:0]      lvl_new;
  logic signed [LEVEL_W:0] diff;
  logic signed [LEVEL_W:0] diff_abs;
  logic [LEVEL_W-1:0]      scale_ext;
  logic [LEVEL_W-1:0]      inv_ext;
  logic signed [LEVEL_W:0] q_s;
  logic [PROD_W-1:0]       acc_next;

  // ---------------------------------------------------------------- APB
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      min_period   <= MIN_PERIOD_RST;
      cutoff_level <= CUTOFF_RST;
      sync_byte    <= SYNC_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MIN_PERIOD: min_period   <= pwdata[PERIOD_W-1:0];
        REG_CUTOFF:     cutoff_level <= pwdata[BYTE_W-1:0];
        REG_SYNC:       sync_byte    <= pwdata[BYTE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_MIN_PERIOD: prdata = PDATA_W'(min_period);
      REG_CUTOFF:     prdata = PDATA_W'(cutoff_level);
      REG_SYNC:       prdata = PDATA_W'(sync_byte);
      default:        prdata = '0;
    endcase
  end

  // match threshold in level units
  always_ff @(posedge clk) begin
    thr <= PROD_W'(cutoff_level) * PROD_W'(LEVEL_SCALE);
  end

  // ---------------------------------------------------------------- datapath
  assign accept     = din.valid && din.ready;
  assign din.ready  = (state == ST_IDLE);

  assign lvl_cur    = level[ch];
  assign step_cur   = step[ch];
  assign left_cur   = left[ch];
  assign fade_cur   = ch ? cmd[3] : cmd[2];
  assign bright_cur = ch ? cmd[1] : cmd[0];

  assign lvl_sum  = $signed({1'b0, lvl_cur}) + step_cur;
  assign lvl_new  = (left_cur != '0) ? lvl_sum[LEVEL_W-1:0] : lvl_cur;

  assign diff     = $signed({1'b0, target}) - $signed({1'b0, lvl_cur});
  assign diff_abs = diff[LEVEL_W] ? -diff : diff;

  assign scale_ext = LEVEL_W'(LEVEL_SCALE);
  assign inv_ext   = LEVEL_W'(FULL_BYTE - bright_cur);

  assign q_s      = $signed({1'b0, div_quo[LEVEL_W-1:0]});
  // MSB-first shift-add of period by the level quotient
  assign acc_next = {acc[PROD_W-2:0], 1'b0} + (mq[Q_W-1] ? PROD_W'(last_period) : '0);

  acpd_div #(
    .DIVIDEND_W (PROD_W),
    .DIVISOR_W  (DVW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    unique case (state)
      ST_IDLE: begin
        if (din.valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        unique case (act)
          ACT_CROSS:     state_next = ST_XSTEP;
          ACT_MATCH_ONE: state_next = ST_MATCH;
          ACT_MATCH_TWO: state_next = ST_MATCH;
          ACT_BYTE:      state_next = (pos == 2'd3) ? ST_TARGET : ST_DONE;
          default:       state_next = ST_DONE;
        endcase
      end
      ST_MATCH:  state_next = ST_DONE;
      ST_TARGET: state_next = ST_LOAD;
      ST_LOAD: begin
        if (fade_cur == '0) begin
          state_next = ch ? ST_DONE : ST_TARGET;
        end else begin
          div_start    = 1'b1;
          div_dividend = PROD_W'(diff_abs[LEVEL_W-1:0]);
          div_divisor  = DVW'({fade_cur, 2'b00});
          state_next   = ST_LDIV;
        end
      end
      ST_LDIV: begin
        if (div_done) state_next = ch ? ST_DONE : ST_TARGET;
      end
      ST_XSTEP: begin
        div_start    = 1'b1;
        div_dividend = PROD_W'(lvl_new);
        div_divisor  = DVW'(LEVEL_SCALE);
        state_next   = ST_XQ;
      end
      ST_XQ: begin
        if (div_done) state_next = ST_XMUL;
      end
      ST_XMUL: begin
        if (mcnt == MCNT_W'(Q_W - 1)) begin
          div_start    = 1'b1;
          div_dividend = acc_next;
          div_divisor  = DVW'(FULL_BYTE);
          state_next   = ST_XDIV;
        end
      end
      ST_XDIV: begin
        if (div_done) state_next = ch ? ST_DONE : ST_XSTEP;
      end
      ST_DONE: begin
        if (!out_valid || dout.ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        level[i] <= LEVEL_W'(LEVEL_MAX);
        step[i]  <= '0;
        left[i]  <= '0;
        delay[i] <= '0;
      end
      last_period <= '0;
      pos         <= '0;
      timer_on    <= 1'b0;
      gate        <= '0;
      armed       <= '0;
      button_flag <= 1'b0;
      sync_now    <= 1'b0;
      ch          <= 1'b0;
      mcnt        <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (accept) sync_now <= 1'b0;
      unique case (state)
        ST_EXEC: begin
          unique case (act)
            ACT_CROSS: begin
              last_period <= period_in;
              button_flag <= !btn_in;
              ch          <= 1'b0;
            end
            ACT_MATCH_ONE: ch <= 1'b0;
            ACT_MATCH_TWO: ch <= 1'b1;
            ACT_BYTE: begin
              if (pos == 2'd3) begin
                pos      <= '0;
                timer_on <= 1'b0;
                ch       <= 1'b0;
              end else begin
                pos      <= pos + 2'd1;
                timer_on <= 1'b1;
              end
            end
            ACT_TIMEOUT: begin
              if (timer_on) begin
                pos      <= '0;
                timer_on <= 1'b0;
                sync_now <= 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
        ST_MATCH: begin
          if (last_period > min_period && PROD_W'(lvl_cur) < thr) gate[ch] <= 1'b1;
        end
        ST_LOAD: begin
          if (fade_cur == '0) begin
            // jump straight to the target
            level[ch] <= target;
            step[ch]  <= '0;
            left[ch]  <= '0;
            ch        <= 1'b1;
          end else begin
            left[ch] <= {fade_cur, 2'b00};
          end
        end
        ST_LDIV: begin
          if (div_done) begin
            step[ch] <= neg ? -q_s : q_s;
            ch       <= 1'b1;
          end
        end
        ST_XSTEP: begin
          if (left_cur != '0) begin
            left[ch]  <= left_cur - 1'b1;
            level[ch] <= lvl_new;
          end
          // zero level fires at once, otherwise wait for the compare match
          if (lvl_new == '0) begin
            armed[ch] <= 1'b0;
            gate[ch]  <= 1'b1;
          end else begin
            armed[ch] <= 1'b1;
            gate[ch]  <= 1'b0;
          end
        end
        ST_XQ: begin
          mcnt <= '0;
        end
        ST_XMUL: begin
          mcnt <= mcnt + 1'b1;
        end
        ST_XDIV: begin
          if (div_done) begin
            delay[ch] <= div_quo[PERIOD_W-1:0];
            ch        <= 1'b1;
          end
        end
        default: begin
        end
      endcase

      if (state == ST_DONE && state_next == ST_IDLE) begin
        out_valid <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      act       <= action_t'(din.action);
      period_in <= din.period_count;
      rx_in     <= din.rx_byte;
      btn_in    <= din.button_low;
    end
    unique case (state)
      ST_EXEC: begin
        if (act == ACT_BYTE) cmd[pos] <= rx_in;
      end
      ST_TARGET: begin
        target <= scale_ext * inv_ext;
      end
      ST_LOAD: begin
        neg <= diff[LEVEL_W];
      end
      ST_XQ: begin
        if (div_done) begin
          mq  <= div_quo[Q_W-1:0];
          acc <= '0;
        end
      end
      ST_XMUL: begin
        acc <= acc_next;
        mq  <= {mq[Q_W-2:0], 1'b0};
      end
      ST_DONE: begin
        if (state_next == ST_IDLE) begin
          out_data.gate            <= gate;
          out_data.delay_one       <= delay[0];
          out_data.delay_two       <= delay[1];
          out_data.armed           <= armed;
          out_data.button_pressed  <= button_flag;
          out_data.send_sync       <= sync_now;
          out_data.timeout_running <= timer_on;
        end
      end
      default: begin
      end
    endcase
  end

  assign dout.valid           = out_valid;
  assign dout.triac_one       = out_data.gate[0];
  assign dout.triac_two       = out_data.gate[1];
  assign dout.delay_one       = out_data.delay_one;
  assign dout.delay_two       = out_data.delay_two;
  assign dout.match_one_armed = out_data.armed[0];
  assign dout.match_two_armed = out_data.armed[1];
  assign dout.button_pressed  = out_data.button_pressed;
  assign dout.send_sync       = out_data.send_sync;
  assign dout.timeout_running = out_data.timeout_running;

  // ---------------------------------------------------------------- checks
  `ACPD_ASSERT_NEXT(a_accept_exec, din.valid && din.ready, state == ST_EXEC, "accepted beat not executed")
  `ACPD_ASSERT_IMP(a_div_done_wait, div_done, state == ST_XQ || state == ST_XDIV || state == ST_LDIV, "divide finished outside a wait state")
  `ACPD_ASSERT_IMP(a_sync_idle, dout.valid && dout.send_sync, !dout.timeout_running, "sync beat with timeout still running")
  `ACPD_ASSERT_IMP(a_level_range, 1'b1, level[0] <= LEVEL_W'(LEVEL_MAX) && level[1] <= LEVEL_W'(LEVEL_MAX), "level above full delay")

endmodule

>>> bench/dimmer_checker.sv
// Dimmer checker: predicts each result beat from accepted events and compares it
module dimmer_checker (
  input  logic                         clk,
  input  logic                         rst,
  acpd_in_if                           din,
  acpd_out_if                          dout,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [acpd_pkg::PADDR_W-1:0] paddr,
  input  logic [acpd_pkg::PDATA_W-1:0] pwdata,
  output int                           errors,
  output int                           results_checked,
  output int                           outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import acpd_pkg::*;

  localparam int LEVEL_SCALE = 10000;
  localparam int FULL_LEVEL  = 255 * LEVEL_SCALE;

  // register copies
  logic [PERIOD_W-1:0] min_period_cfg;
  logic [BYTE_W-1:0]   cutoff_cfg;
  logic [BYTE_W-1:0]   sync_cfg;

  // channel and command state
  int                  level [2];
  int                  fade_step [2];
  int                  fades_left [2];
  logic [PERIOD_W-1:0] period_seen;
  logic [BYTE_W-1:0]   cmd_bytes [CMD_LEN];
  logic [1:0]          byte_pos;
  logic                timer_run;
  logic [1:0]          gate;
  logic [1:0]          armed;
  logic [PERIOD_W-1:0] fire_delay [2];
  logic                pressed;

  result_t             status_due [$];
  result_t             want;

  initial begin
    errors = 0;
    results_checked = 0;
  end

  task automatic report_error(input string msg);
    errors++;
    $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] got_v);
    if (got_v !== exp_v)
      report_error($sformatf("result %0d field %s: expected %0d, got %0d",
                             results_checked, name, exp_v, got_v));
  endtask

  function automatic void reset_dimmer();
    min_period_cfg = MIN_PERIOD_RST;
    cutoff_cfg     = CUTOFF_RST;
    sync_cfg       = SYNC_RST;
    for (int ch = 0; ch < 2; ch++) begin
      level[ch]      = FULL_LEVEL;
      fade_step[ch]  = 0;
      fades_left[ch] = 0;
      fire_delay[ch] = '0;
    end
    for (int i = 0; i < CMD_LEN; i++) cmd_bytes[i] = '0;
    period_seen = '0;
    byte_pos    = '0;
    timer_run   = 1'b0;
    gate        = '0;
    armed       = '0;
    pressed     = 1'b0;
  endfunction

  function automatic void load_fade_target(input int ch, input logic [7:0] bright,
                                           input logic [7:0] fade);
    int target;
    int n;
    target = LEVEL_SCALE * (255 - int'(bright));
    if (fade == 8'd0) begin
      // zero fade length: jump straight to the target
      level[ch]      = target;
      fade_step[ch]  = 0;
      fades_left[ch] = 0;
    end else begin
      n = 4 * int'(fade);
      fade_step[ch]  = (target - level[ch]) / n;
      fades_left[ch] = n;
    end
  endfunction

  function automatic void advance_channel(input int ch);
    int unsigned q;
    int unsigned prod;
    if (fades_left[ch] != 0) begin
      fades_left[ch]--;
      level[ch] += fade_step[ch];
    end
    q    = int'(level[ch] / LEVEL_SCALE);
    prod = {16'd0, period_seen} * q;
    fire_delay[ch] = 16'(prod / 255);
    if (level[ch] == 0) begin
      armed[ch] = 1'b0;
      gate[ch]  = 1'b1;
    end else begin
      armed[ch] = 1'b1;
      gate[ch]  = 1'b0;
    end
  endfunction

  function automatic void apply_match(input int ch);
    if (period_seen > min_period_cfg && level[ch] < int'(cutoff_cfg) * LEVEL_SCALE)
      gate[ch] = 1'b1;
  endfunction

  function automatic result_t step_dimmer(input logic [ACTION_W-1:0] act,
                                          input logic [PERIOD_W-1:0] per,
                                          input logic [BYTE_W-1:0] rxb,
                                          input logic btn);
    result_t r;
    logic    sync_now;
    sync_now = 1'b0;
    case (act)
      ACT_CROSS: begin
        period_seen = per;
        advance_channel(0);
        advance_channel(1);
        pressed = !btn;
      end
      ACT_MATCH_ONE: apply_match(0);
      ACT_MATCH_TWO: apply_match(1);
      ACT_BYTE: begin
        cmd_bytes[byte_pos] = rxb;
        if (byte_pos == 2'd3) begin
          byte_pos  = '0;
          timer_run = 1'b0;
          load_fade_target(0, cmd_bytes[0], cmd_bytes[2]);
          load_fade_target(1, cmd_bytes[1], cmd_bytes[3]);
        end else begin
          byte_pos  = byte_pos + 2'd1;
          timer_run = 1'b1;
        end
      end
      ACT_TIMEOUT: begin
        if (timer_run) begin
          byte_pos  = '0;
          timer_run = 1'b0;
          sync_now  = 1'b1;
        end
      end
      default: ;
    endcase
    r.gate            = gate;
    r.delay_one       = fire_delay[0];
    r.delay_two       = fire_delay[1];
    r.armed           = armed;
    r.button_pressed  = pressed;
    r.send_sync       = sync_now;
    r.timeout_running = timer_run;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      reset_dimmer();
      status_due.delete();
    end else begin
      // compare first: a beat leaving now never belongs to an event entering now
      if (dout.valid && dout.ready) begin
        if (status_due.size() == 0) begin
          report_error("result beat with no event waiting");
        end else begin
          want = status_due.pop_front();
          check_field("triac_one", want.gate[0], dout.triac_one);
          check_field("triac_two", want.gate[1], dout.triac_two);
          check_field("delay_one", want.delay_one, dout.delay_one);
          check_field("delay_two", want.delay_two, dout.delay_two);
          check_field("match_one_armed", want.armed[0], dout.match_one_armed);
          check_field("match_two_armed", want.armed[1], dout.match_two_armed);
          check_field("button_pressed", want.button_pressed, dout.button_pressed);
          check_field("send_sync", want.send_sync, dout.send_sync);
          check_field("timeout_running", want.timeout_running, dout.timeout_running);
          results_checked++;
        end
      end
      if (din.valid && din.ready)
        status_due.push_back(step_dimmer(din.action, din.period_count, din.rx_byte,
                                         din.button_low));
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_MIN_PERIOD: min_period_cfg = pwdata[PERIOD_W-1:0];
          REG_CUTOFF:     cutoff_cfg     = pwdata[BYTE_W-1:0];
          REG_SYNC:       sync_cfg       = pwdata[BYTE_W-1:0];
          default: ;
        endcase
      end
    end
    outstanding <= status_due.size();
  end

endmodule

>>> bench/tb_ac_phase_dimmer_with_fade_unit.sv
// Testbench top: drives events and register writes into the dimmer and gives the verdict
module tb_ac_phase_dimmer_with_fade_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import acpd_pkg::*;

  localparam int              CYCLE_LIMIT  = 1000000;
  localparam int              PHASE_EVENTS = 250;
  localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int errors;
  int results_checked;
  int outstanding;
  int cycles = 0;
  int send_idle = 0;
  int stall_pct;
  int counted;
  int per_action [8];

  acpd_in_if  in_ch();
  acpd_out_if out_ch();

  ac_phase_dimmer_with_fade_unit dut (
    .clk    (clk),
    .rst    (rst),
    .din    (in_ch),
    .dout   (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  dimmer_checker watch (
    .clk            (clk),
    .rst            (rst),
    .din            (in_ch),
    .dout           (out_ch),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .errors         (errors),
    .results_checked(results_checked),
    .outstanding    (outstanding)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_event(input logic [ACTION_W-1:0] act, input logic [PERIOD_W-1:0] per,
                            input logic [BYTE_W-1:0] rxb, input logic btn);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.action       <= act;
    in_ch.period_count <= per;
    in_ch.rx_byte      <= rxb;
    in_ch.button_low   <= btn;
    do @(posedge clk); while (!in_ch.ready);
    per_action[act]++;
    if (act <= ACT_BYTE) counted++;
  endtask

  // hold the sender off until every result beat is back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [PERIOD_W-1:0] pick_period();
    case ($urandom_range(9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(50000, 15000));
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] pick_bright();
    case ($urandom_range(7))
      0:       return 8'd0;
      1:       return FULL_BYTE;
      2:       return 8'($urandom_range(250, 255));
      3:       return 8'($urandom_range(1, 7));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] pick_fade();
    case ($urandom_range(9))
      0, 1:    return 8'd0;
      2:       return FULL_BYTE;
      3:       return 8'($urandom_range(5, 40));
      default: return 8'($urandom_range(1, 4));
    endcase
  endfunction

  task automatic send_cross();
    send_event(ACT_CROSS, pick_period(), 8'($urandom), 1'($urandom));
  endtask

  task automatic send_match(input action_t act);
    send_event(act, 16'($urandom), 8'($urandom), 1'($urandom));
  endtask

  task automatic send_timeout(input bit after_partial);
    send_event(ACT_TIMEOUT, 16'($urandom), 8'($urandom), 1'($urandom));
    if (after_partial) counted++;
  endtask

  // first count bytes of a command: brightness one, brightness two, fade one, fade two
  task automatic send_command(input int count);
    logic [BYTE_W-1:0] cmd [CMD_LEN];
    cmd[0] = pick_bright();
    cmd[1] = pick_bright();
    cmd[2] = pick_fade();
    cmd[3] = pick_fade();
    for (int i = 0; i < count; i++)
      send_event(ACT_BYTE, 16'($urandom), cmd[i], 1'($urandom));
  endtask

  task automatic load_command(input logic [7:0] b0, input logic [7:0] b1,
                              input logic [7:0] b2, input logic [7:0] b3);
    send_event(ACT_BYTE, 16'd0, b0, 1'b1);
    send_event(ACT_BYTE, 16'hFFFF, b1, 1'b0);
    send_event(ACT_BYTE, 16'd0, b2, 1'b1);
    send_event(ACT_BYTE, 16'hFFFF, b3, 1'b0);
  endtask

  task automatic random_burst();
    int r;
    r = $urandom_range(99);
    if (r < 40) begin
      send_cross();
      if ($urandom_range(3) != 0) send_match($urandom_range(1) ? ACT_MATCH_ONE : ACT_MATCH_TWO);
      if ($urandom_range(3) != 0) send_match($urandom_range(1) ? ACT_MATCH_ONE : ACT_MATCH_TWO);
    end else if (r < 65) begin
      send_command(CMD_LEN);
    end else if (r < 75) begin
      send_command($urandom_range(3, 1));
      if ($urandom_range(4) != 0) send_timeout(1'b1);
    end else if (r < 85) begin
      send_match($urandom_range(1) ? ACT_MATCH_ONE : ACT_MATCH_TWO);
    end else if (r < 91) begin
      send_timeout(1'b0);
    end else if (r < 96) begin
      send_command(1);
    end else begin
      send_event(3'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO)), 16'($urandom),
                 8'($urandom), 1'($urandom));
    end
  endtask

  task automatic configure_phase(input int ph);
    case (ph)
      0: begin
        write_reg(REG_MIN_PERIOD, 32'd0);
        write_reg(REG_CUTOFF, 32'(FULL_BYTE));
        write_reg(REG_SYNC, 32'd0);
      end
      1: begin
        write_reg(REG_MIN_PERIOD, 32'hFFFF);
        write_reg(REG_CUTOFF, 32'd0);
        write_reg(REG_SYNC, 32'(FULL_BYTE));
      end
      2: begin
        write_reg(REG_MIN_PERIOD, 32'($urandom_range(45000, 15000)));
        write_reg(REG_CUTOFF, 32'($urandom_range(254, 1)));
        write_reg(REG_SYNC, 32'($urandom_range(255)));
      end
      default: begin
        write_reg(REG_MIN_PERIOD, 32'(MIN_PERIOD_RST));
        write_reg(REG_CUTOFF, 32'(CUTOFF_RST));
        write_reg(REG_SYNC, 32'(SYNC_RST));
      end
    endcase
  endtask

  initial begin
    int total;
    in_ch.valid        <= 1'b0;
    in_ch.action       <= ACT_CROSS;
    in_ch.period_count <= '0;
    in_ch.rx_byte      <= '0;
    in_ch.button_low   <= 1'b1;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    stall_pct          <= 0;
    for (int i = 0; i < 8; i++) per_action[i] = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed part under power-up register values
    send_event(ACT_MATCH_ONE, 16'd0, 8'd0, 1'b1);       // no period yet: no fire
    send_event(ACT_TIMEOUT, 16'd0, 8'd0, 1'b1);         // nothing pending: ignored
    send_event(ACT_SPARE_LO, 16'hFFFF, FULL_BYTE, 1'b0);
    send_event(ACT_SPARE_HI, 16'hFFFF, FULL_BYTE, 1'b0);
    send_event(ACT_CROSS, 16'hFFFF, 8'd0, 1'b0);        // full delay, button down
    send_event(ACT_MATCH_TWO, 16'd0, 8'd0, 1'b1);       // level above cutoff: no fire
    load_command(FULL_BYTE, 8'd0, 8'd0, 8'd0);          // instant jumps
    send_event(ACT_CROSS, 16'd0, FULL_BYTE, 1'b1);      // zero level fires at once
    send_event(ACT_MATCH_ONE, 16'd0, 8'd0, 1'b1);       // match while disarmed
    load_command(8'd10, 8'd250, 8'd1, FULL_BYTE);
    send_event(ACT_CROSS, 16'd40000, 8'd0, 1'b1);       // releases gate one
    send_event(ACT_MATCH_ONE, 16'd0, 8'd0, 1'b1);
    send_event(ACT_MATCH_TWO, 16'd0, 8'd0, 1'b1);
    send_event(ACT_BYTE, 16'd0, 8'd0, 1'b1);
    send_event(ACT_TIMEOUT, 16'd0, 8'd0, 1'b1);         // one byte pending: resync
    send_event(ACT_BYTE, 16'd0, FULL_BYTE, 1'b1);
    send_event(ACT_BYTE, 16'd0, FULL_BYTE, 1'b1);
    send_event(ACT_BYTE, 16'd0, FULL_BYTE, 1'b1);
    send_event(ACT_TIMEOUT, 16'd0, 8'd0, 1'b1);         // three bytes pending
    send_event(ACT_CROSS, MIN_PERIOD_RST, 8'd0, 1'b0);
    send_event(ACT_MATCH_ONE, 16'd0, 8'd0, 1'b1);       // period equal to min: no fire

    for (int ph = 0; ph < 4; ph++) begin
      drain_results();
      configure_phase(ph);
      case (ph)
        0:       begin send_idle = 0;  stall_pct <= 0;  end
        1:       begin send_idle = 85; stall_pct <= 0;  end
        2:       begin send_idle = 0;  stall_pct <= 85; end
        default: begin send_idle = 14; stall_pct <= 14; end
      endcase
      counted = 0;
      while (counted < PHASE_EVENTS) random_burst();
    end

    drain_results();
    repeat (150) @(posedge clk);

    total = 0;
    for (int i = 0; i < 8; i++) total += per_action[i];
    $display("Covered %0d events: %0d zero crosses, %0d matches, %0d bytes, %0d timeouts, %0d spare",
             total, per_action[ACT_CROSS], per_action[ACT_MATCH_ONE] + per_action[ACT_MATCH_TWO],
             per_action[ACT_BYTE], per_action[ACT_TIMEOUT],
             per_action[5] + per_action[6] + per_action[7]);
    $display("%0d result beats compared over four handshake mixes and four register settings",
             results_checked);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/acpd_pkg.sv
rtl/acpd_if.sv
rtl/acpd_div.sv
rtl/ac_phase_dimmer_with_fade_unit.sv
bench/dimmer_checker.sv
bench/tb_ac_phase_dimmer_with_fade_unit.sv
